// ----- hw/rtl/ebr_pkg.sv -----
// Shared types and constants of the embedding bag reducer.
package ebr_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_ADD       = 2'd1,
        CMD_ADD_CLOSE = 2'd2,
        CMD_CLOSE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RED_SUM  = 2'd0,
        RED_MEAN = 2'd1,
        RED_MAX  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_PAD    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_WEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CLEAR,
        ST_CLOSE,
        ST_FETCH,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WORD_W = 16;
    localparam int ACC_W = 32;
    localparam int ROW_OUT_W = 11;
    localparam int COUNT_W = 16;
    localparam int COL_W = 6;
    localparam logic [ROW_OUT_W-1:0] NO_ROW = '1;

endpackage

// ----- hw/rtl/ebr_divider.sv -----
// Restoring divider for the mean: signed 32-bit dividend by unsigned 16-bit count.
module ebr_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [16:0] rem_reg;
    logic [16:0] rem_next;
    logic [15:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [16:0] trial;

    always_comb
    begin
        trial = {rem_reg[15:0], quo_reg[31]} - {1'b0, dvs_reg};
        if (!trial[16])
        begin
            rem_next = trial;
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[15:0], quo_reg[31]};
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'd0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            neg_reg <= dividend[31];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = run_reg && (cnt_reg == 6'd31);
    assign quotient = neg_reg ? (32'd0 - quo_next) : quo_next;

endmodule

// ----- hw/rtl/ebr_table.sv -----
// Embedding table memory: one word written, one row slice of words read a cycle.
module ebr_table #(
    parameter int ROWS  = 1024,
    parameter int LANES = 16,
    parameter int SLICES = 4,
    parameter int ROW_W = 10,
    parameter int SL_W = 2,
    parameter int LN_W = 4
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ROW_W-1:0]        wr_row,
    input  logic [SL_W-1:0]         wr_slice,
    input  logic [LN_W-1:0]         wr_lane,
    input  logic [15:0]             wr_data,
    input  logic                    rd_en,
    input  logic [ROW_W-1:0]        rd_row,
    input  logic [SL_W-1:0]         rd_slice,
    output logic [LANES-1:0][15:0]  rd_data
);

    localparam int DEPTH = ROWS * SLICES;
    localparam int ADDR_W = ROW_W + SL_W;

    logic [LANES-1:0][15:0] mem [DEPTH];
    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] ra;

    assign wa = {wr_row, wr_slice};
    assign ra = {rd_row, rd_slice};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wa][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[ra];
        end
    end

endmodule

// ----- hw/rtl/ebr_accum.sv -----
// Per-column accumulator memory holding the sum, the max and the max row of each column.
module ebr_accum #(
    parameter int LANES = 16,
    parameter int SLICES = 4,
    parameter int SL_W = 2
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [SL_W-1:0]                     rd_slice,
    output logic [LANES-1:0][58:0]              rd_data,
    input  logic                                wr_en,
    input  logic [SL_W-1:0]                     wr_slice,
    input  logic [LANES-1:0][58:0]              wr_data
);

    logic [LANES-1:0][58:0] mem [SLICES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slice] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_slice];
        end
    end

endmodule

// ----- hw/rtl/embedding_bag_reduce.sv -----
// Top level of the embedding bag reducer.
// An item is taken when start is high and busy is low. A table write leaves the block idle. An
// add sweeps the row in slices of 16 words through a read-modify-write of the accumulator
// memory. A close steps through an accumulator read, a fetch and the result beat for each
// used column; in mean mode a serial divider sits between the fetch and the beat of every
// column. The close then clears the accumulators one slice per cycle. The receiver cannot
// stall: results appear for one cycle each under out_valid. After reset the accumulators are
// cleared slice by slice while busy is high.
module embedding_bag_reduce #(
    parameter int TABLE_ROWS = 1024,
    parameter int MAX_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          cmd,
    input  logic [9:0]          row,
    input  logic [5:0]          col,
    input  logic signed [15:0]  word,
    input  logic signed [15:0]  sample_weight,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    output logic                out_valid,
    output logic signed [31:0]  value,
    output logic signed [10:0]  max_row,
    output logic [15:0]         bag_count,
    output logic [5:0]          column,
    output logic                last
);

    localparam int LANES = 16;
    localparam int SLICES = (MAX_WIDTH + LANES - 1) / LANES;
    localparam int SL_W = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int LN_W = 4;
    localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

    ebr_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [10:0] pad_reg;
    logic [6:0]  width_reg;
    logic        wen_reg;
    logic [15:0] count_reg;
    logic        first_reg;
    logic [9:0]  arow_reg;
    logic signed [15:0] aw_reg;
    logic        oor_reg;
    logic [SL_W-1:0] sl_reg;
    logic        ph_reg;
    logic [5:0]  col_reg;
    logic        dstart_reg;
    logic [6:0]  used_w;
    logic [5:0]  last_col;
    logic [SL_W-1:0] last_sl;
    logic        take;
    logic        kept;

    logic [LANES-1:0][15:0] t_rd;
    logic [LANES-1:0][58:0] a_rd;
    logic [LANES-1:0][58:0] a_wr;
    logic        a_rd_en;
    logic [SL_W-1:0] a_rd_sl;
    logic        a_wr_en;
    logic        d_done;
    logic [31:0] d_quo;
    logic [58:0] cur;

    assign used_w = (width_reg == 7'd0) ? 7'd1 :
                    (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
    assign last_col = 6'(used_w - 7'd1);
    assign last_sl = SL_W'(last_col >> LN_W);
    assign take = start && !busy;
    assign kept = !($signed({1'b0, row}) == $signed(pad_reg));
    assign busy = (state_reg != ebr_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'd0;
            pad_reg <= ebr_pkg::NO_ROW;
            width_reg <= 7'd64;
            wen_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (ebr_pkg::reg_idx_t'(cfg_index))
                ebr_pkg::REG_MODE:   mode_reg <= cfg_data[1:0];
                ebr_pkg::REG_PAD:    pad_reg <= cfg_data;
                ebr_pkg::REG_WIDTH:  width_reg <= cfg_data[6:0];
                ebr_pkg::REG_WEIGHT: wen_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ebr_table #(.ROWS(TABLE_ROWS), .LANES(LANES), .SLICES(SLICES), .ROW_W(ROW_W),
                .SL_W(SL_W), .LN_W(LN_W)) u_table (
        .clk(clk),
        .wr_en(take && cmd == ebr_pkg::CMD_WRITE && {22'd0, row} < TABLE_ROWS
               && {26'd0, col} < MAX_WIDTH),
        .wr_row(ROW_W'(row)),
        .wr_slice(SL_W'(col >> LN_W)),
        .wr_lane(col[3:0]),
        .wr_data(word),
        .rd_en(state_reg == ebr_pkg::ST_ADD && !ph_reg),
        .rd_row(ROW_W'(arow_reg)),
        .rd_slice(sl_reg),
        .rd_data(t_rd)
    );

    always_comb
    begin
        a_rd_en = 1'b0;
        a_rd_sl = sl_reg;
        if (state_reg == ebr_pkg::ST_ADD && !ph_reg)
        begin
            a_rd_en = 1'b1;
        end
        else if (state_reg == ebr_pkg::ST_CLOSE)
        begin
            a_rd_en = 1'b1;
            a_rd_sl = SL_W'(col_reg >> LN_W);
        end
    end

    ebr_accum #(.LANES(LANES), .SLICES(SLICES), .SL_W(SL_W)) u_accum (
        .clk(clk),
        .rd_en(a_rd_en),
        .rd_slice(a_rd_sl),
        .rd_data(a_rd),
        .wr_en(a_wr_en),
        .wr_slice(sl_reg),
        .wr_data(a_wr)
    );

    // Lane update: saturating sum plus running max with its row, or a cleared entry in the clear state.
    always_comb
    begin
        a_wr_en = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            logic signed [15:0] v;
            logic signed [31:0] p;
            logic signed [31:0] term;
            logic signed [32:0] s;
            logic signed [31:0] acc;
            logic signed [15:0] mx;
            v = oor_reg ? 16'sd0 : $signed(t_rd[i]);
            p = v * aw_reg;
            term = wen_reg ? (p >>> 8) : 32'(v);
            acc = $signed(a_rd[i][58:27]);
            mx = $signed(a_rd[i][26:11]);
            s = 33'(acc) + 33'(term);
            if (state_reg == ebr_pkg::ST_CLEAR)
            begin
                a_wr[i] = {32'd0, 16'd0, ebr_pkg::NO_ROW};
            end
            else
            begin
                a_wr[i] = a_rd[i];
                if (6'({sl_reg, i[LN_W-1:0]}) <= last_col)
                begin
                    a_wr[i][58:27] = (s > 33'sh07FFFFFFF) ? 32'h7FFFFFFF :
                                     (s < -33'sh080000000) ? 32'h80000000 : s[31:0];
                    if (first_reg || v > mx)
                    begin
                        a_wr[i][26:11] = v;
                        a_wr[i][10:0] = {1'b0, arow_reg};
                    end
                end
            end
        end
        if ((state_reg == ebr_pkg::ST_ADD && ph_reg) || state_reg == ebr_pkg::ST_CLEAR)
        begin
            a_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ebr_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if ((cmd == ebr_pkg::CMD_ADD || cmd == ebr_pkg::CMD_ADD_CLOSE) && kept)
                    begin
                        state_next = ebr_pkg::ST_ADD;
                    end
                    else if (cmd == ebr_pkg::CMD_ADD_CLOSE || cmd == ebr_pkg::CMD_CLOSE)
                    begin
                        state_next = ebr_pkg::ST_CLOSE;
                    end
                end
            end
            ebr_pkg::ST_ADD:
            begin
                if (ph_reg && sl_reg == last_sl)
                begin
                    state_next = dstart_reg ? ebr_pkg::ST_CLOSE : ebr_pkg::ST_IDLE;
                end
            end
            ebr_pkg::ST_CLOSE:
            begin
                state_next = ebr_pkg::ST_FETCH;
            end
            ebr_pkg::ST_FETCH:
            begin
                state_next = (mode_reg == ebr_pkg::RED_MEAN) ? ebr_pkg::ST_DIV
                                                             : ebr_pkg::ST_EMIT;
            end
            ebr_pkg::ST_DIV:
            begin
                if (d_done)
                begin
                    state_next = ebr_pkg::ST_EMIT;
                end
            end
            ebr_pkg::ST_EMIT:
            begin
                state_next = (col_reg == last_col) ? ebr_pkg::ST_CLEAR : ebr_pkg::ST_CLOSE;
            end
            ebr_pkg::ST_CLEAR:
            begin
                if (sl_reg == SL_W'(SLICES - 1))
                begin
                    state_next = ebr_pkg::ST_IDLE;
                end
            end
            default: state_next = ebr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ebr_pkg::ST_CLEAR;
            sl_reg <= '0;
            ph_reg <= 1'b0;
            col_reg <= '0;
            count_reg <= '0;
            first_reg <= 1'b1;
            dstart_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ebr_pkg::ST_IDLE:
                begin
                    sl_reg <= '0;
                    ph_reg <= 1'b0;
                    col_reg <= '0;
                    dstart_reg <= (cmd == ebr_pkg::CMD_ADD_CLOSE);
                end
                ebr_pkg::ST_ADD:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (sl_reg == last_sl)
                        begin
                            sl_reg <= '0;
                            first_reg <= 1'b0;
                            if (count_reg != 16'hFFFF)
                            begin
                                count_reg <= count_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            sl_reg <= sl_reg + SL_W'(1);
                        end
                    end
                end
                ebr_pkg::ST_EMIT:
                begin
                    col_reg <= col_reg + 6'd1;
                end
                ebr_pkg::ST_CLEAR:
                begin
                    if (sl_reg == SL_W'(SLICES - 1))
                    begin
                        sl_reg <= '0;
                        count_reg <= '0;
                        first_reg <= 1'b1;
                    end
                    else
                    begin
                        sl_reg <= sl_reg + SL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            arow_reg <= row;
            aw_reg <= sample_weight;
            oor_reg <= !({22'd0, row} < TABLE_ROWS);
        end
    end

    assign cur = a_rd[col_reg[3:0]];

    ebr_divider u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(state_reg == ebr_pkg::ST_FETCH && mode_reg == ebr_pkg::RED_MEAN),
        .dividend(cur[58:27]),
        .divisor(count_reg),
        .done(d_done),
        .quotient(d_quo)
    );

    logic [31:0] res_reg;
    logic [31:0] res_next;

    always_comb
    begin
        res_next = res_reg;
        if (state_reg == ebr_pkg::ST_FETCH && mode_reg != ebr_pkg::RED_MEAN)
        begin
            res_next = (mode_reg == ebr_pkg::RED_MAX) ? {{16{cur[26]}}, cur[26:11]}
                                                      : cur[58:27];
        end
        else if (d_done)
        begin
            res_next = (count_reg == 16'd0) ? 32'd0 : d_quo;
        end
    end

    logic [10:0] mrow_reg;

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == ebr_pkg::ST_FETCH)
        begin
            mrow_reg <= (mode_reg == ebr_pkg::RED_MAX) ? cur[10:0] : ebr_pkg::NO_ROW;
        end
    end

    assign out_valid = (state_reg == ebr_pkg::ST_EMIT);
    assign value = res_reg;
    assign max_row = mrow_reg;
    assign bag_count = count_reg;
    assign column = col_reg;
    assign last = (col_reg == last_col);

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("two results in adjacent cycles");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result while idle");
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> state_reg == ebr_pkg::ST_CLEAR)
        else $error("bag not cleared after last column");

endmodule

// ----- tb/sv/embedding_bag_reduce_test.sv -----
// Self-checking testbench of the embedding bag reducer: directed table, random bags, predictor.
module embedding_bag_reduce_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS = 1024;
    localparam int COLS = 64;
    localparam int POOL_N = 3;
    localparam int PHASE_ITEMS = 18;
    localparam int SETTLE_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] cmd = ebr_pkg::CMD_WRITE;
    logic [9:0] row = '0;
    logic [5:0] col = '0;
    logic signed [15:0] word = '0;
    logic signed [15:0] sample_weight = '0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = ebr_pkg::REG_MODE;
    logic [10:0] cfg_data = '0;
    logic busy;
    logic out_valid;
    logic signed [31:0] value;
    logic signed [10:0] max_row;
    logic [15:0] bag_count;
    logic [5:0] column;
    logic last;

    embedding_bag_reduce u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .row(row),
        .col(col), .word(word), .sample_weight(sample_weight), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid), .value(value),
        .max_row(max_row), .bag_count(bag_count), .column(column), .last(last)
    );

    typedef struct {
        logic signed [31:0] value;
        logic signed [10:0] max_row;
        logic [15:0]        count;
        logic [5:0]         column;
        logic               last;
    } col_res_t;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         idx;
        logic [10:0]        data;
        logic [1:0]         c;
        logic [9:0]         r;
        logic signed [15:0] wd;
        logic signed [15:0] wt;
        bit                 typed;
        logic signed [31:0] tv;
        logic signed [10:0] tmr;
        logic [15:0]        tc;
    } script_row_t;

    col_res_t pending_cols[$];
    script_row_t script[$];
    int errors = 0;
    int items_sent = 0;
    int bags_closed = 0;
    int results_seen = 0;
    int idle_pct = 0;

    logic signed [15:0] emb [ROWS][COLS];
    longint col_sum [COLS];
    logic signed [15:0] col_peak [COLS];
    logic signed [10:0] col_peak_row [COLS];
    int kept;
    logic [1:0] cur_mode;
    logic signed [10:0] cur_pad;
    logic [6:0] cur_width;
    logic cur_weighted;
    int pool [POOL_N];

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("** embedding_bag_reduce: FAILED **");
        $finish;
    end

    function automatic int live_width();
        if (cur_width == 0) return 1;
        if (cur_width > COLS) return COLS;
        return cur_width;
    endfunction

    function automatic void clear_bag_model();
        for (int c = 0; c < COLS; c++) begin
            col_sum[c] = 0;
            col_peak[c] = '0;
            col_peak_row[c] = ebr_pkg::NO_ROW;
        end
        kept = 0;
    endfunction

    function automatic void fold_row(logic [9:0] r, logic signed [15:0] wt);
        int w;
        bit first;
        longint v;
        longint wl;
        longint term;
        longint s;
        w = live_width();
        first = (kept == 0);
        wl = wt;
        if (cur_pad == $signed({1'b0, r})) return;
        for (int c = 0; c < w; c++) begin
            v = emb[r][c];
            term = cur_weighted ? ((v * wl) >>> 8) : v;
            s = col_sum[c] + term;
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            col_sum[c] = s;
            if (first || v > col_peak[c]) begin
                col_peak[c] = emb[r][c];
                col_peak_row[c] = $signed({1'b0, r});
            end
        end
        if (kept < 65535) kept++;
    endfunction

    function automatic void close_bag_model(bit typed, logic signed [31:0] tv,
                                            logic signed [10:0] tmr, logic [15:0] tc);
        int w;
        col_res_t res;
        w = live_width();
        for (int c = 0; c < w; c++) begin
            res.max_row = ebr_pkg::NO_ROW;
            if (cur_mode == ebr_pkg::RED_MAX) begin
                res.value = 32'(col_peak[c]);
                res.max_row = col_peak_row[c];
            end else if (cur_mode == ebr_pkg::RED_MEAN) begin
                res.value = (kept != 0) ? 32'(col_sum[c] / kept) : 32'sd0;
            end else begin
                res.value = 32'(col_sum[c]);
            end
            res.count = 16'(kept);
            if (typed) begin
                res.value = tv;
                res.max_row = tmr;
                res.count = tc;
            end
            res.column = 6'(c);
            res.last = (c + 1 == w);
            pending_cols.push_back(res);
        end
        bags_closed++;
        clear_bag_model();
    endfunction

    always @(posedge clk) begin
        col_res_t exp_col;
        if (rst_n && out_valid) begin
            results_seen++;
            if (pending_cols.size() == 0) begin
                $error("result beat with no expectation: column %0d value %0d", column, value);
                errors++;
            end else begin
                exp_col = pending_cols.pop_front();
                if (value !== exp_col.value) begin
                    $error("value: expected %0d, got %0d", exp_col.value, value);
                    errors++;
                end
                if (max_row !== exp_col.max_row) begin
                    $error("max_row: expected %0d, got %0d", exp_col.max_row, max_row);
                    errors++;
                end
                if (bag_count !== exp_col.count) begin
                    $error("bag_count: expected %0d, got %0d", exp_col.count, bag_count);
                    errors++;
                end
                if (column !== exp_col.column) begin
                    $error("column: expected %0d, got %0d", exp_col.column, column);
                    errors++;
                end
                if (last !== exp_col.last) begin
                    $error("last: expected %0d, got %0d", exp_col.last, last);
                    errors++;
                end
            end
        end
    end

    task automatic drive_item(ebr_pkg::cmd_t c, logic [9:0] r, logic [5:0] k,
                              logic signed [15:0] wd, logic signed [15:0] wt, bit typed = 0,
                              logic signed [31:0] tv = 0,
                              logic signed [10:0] tmr = ebr_pkg::NO_ROW,
                              logic [15:0] tc = 0);
        cmd <= c;
        row <= r;
        col <= k;
        word <= wd;
        sample_weight <= wt;
        start <= 1'b1;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        items_sent++;
        case (c)
            ebr_pkg::CMD_WRITE: emb[r][k] = wd;
            ebr_pkg::CMD_ADD: fold_row(r, wt);
            ebr_pkg::CMD_ADD_CLOSE:
            begin
                fold_row(r, wt);
                close_bag_model(typed, tv, tmr, tc);
            end
            default: close_bag_model(typed, tv, tmr, tc);
        endcase
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_cols.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(ebr_pkg::reg_idx_t i, logic [10:0] d);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= i;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (i)
            ebr_pkg::REG_MODE: cur_mode = d[1:0];
            ebr_pkg::REG_PAD: cur_pad = d;
            ebr_pkg::REG_WIDTH: cur_width = d[6:0];
            default: cur_weighted = d[0];
        endcase
    endtask

    function automatic void script_cfg(ebr_pkg::reg_idx_t i, logic [10:0] d);
        script_row_t s;
        s = '{default: '0};
        s.is_cfg = 1;
        s.idx = i;
        s.data = d;
        script.push_back(s);
    endfunction

    function automatic void script_item(ebr_pkg::cmd_t c, logic [9:0] r, logic [5:0] k,
                                        logic signed [15:0] wd, logic signed [15:0] wt,
                                        bit typed = 0, logic signed [31:0] tv = 0,
                                        logic signed [10:0] tmr = ebr_pkg::NO_ROW,
                                        logic [15:0] tc = 0);
        script_row_t s;
        s = '{default: '0};
        s.c = c;
        s.r = r;
        s.idx = ebr_pkg::REG_MODE;
        s.wd = wd;
        s.wt = wt;
        s.data = 11'(k);
        s.typed = typed;
        s.tv = tv;
        s.tmr = tmr;
        s.tc = tc;
        script.push_back(s);
    endfunction

    task automatic random_bag();
        int n;
        logic [9:0] r;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                drive_item(ebr_pkg::CMD_WRITE, 10'(pool[$urandom_range(POOL_N - 1)]),
                           6'($urandom), 16'($urandom), 16'($urandom));
                sender_gap();
            end
            r = 10'(pool[$urandom_range(POOL_N - 1)]);
            if (cur_pad >= 0 && $urandom_range(7) == 0) r = cur_pad[9:0];
            drive_item(ebr_pkg::CMD_ADD, r, 6'($urandom), 16'($urandom), 16'($urandom));
            sender_gap();
        end
        if ($urandom_range(1) == 0)
            drive_item(ebr_pkg::CMD_ADD_CLOSE, 10'(pool[$urandom_range(POOL_N - 1)]),
                       6'($urandom), 16'($urandom), 16'($urandom));
        else
            drive_item(ebr_pkg::CMD_CLOSE, 10'($urandom), 6'($urandom), 16'($urandom),
                       16'($urandom));
        sender_gap();
    endtask

    initial begin
        int phase_idle [4] = '{0, 67, 0, 24};
        logic [1:0] ph_mode [6] = '{ebr_pkg::RED_SUM, ebr_pkg::RED_MEAN, ebr_pkg::RED_MAX,
                                    2'd3, ebr_pkg::RED_MEAN, ebr_pkg::RED_MAX};
        logic [6:0] ph_width [6] = '{7'd64, 7'd5, 7'd1, 7'd0, 7'd127, 7'd17};
        logic ph_weighted [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        int phase_start;
        script_row_t s;

        clear_bag_model();
        cur_mode = ebr_pkg::RED_SUM;
        cur_pad = ebr_pkg::NO_ROW;
        cur_width = 7'd64;
        cur_weighted = 1'b0;
        pool[0] = 0;
        pool[1] = ROWS - 1;
        for (int p = 2; p < POOL_N; p++) pool[p] = $urandom_range(1, ROWS - 2);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < POOL_N; p++)
            for (int c = 0; c < COLS; c++)
                drive_item(ebr_pkg::CMD_WRITE, 10'(pool[p]), 6'(c), 16'($urandom),
                           16'($urandom));

        script_item(ebr_pkg::CMD_CLOSE, 0, 0, 0, 0, 1, 0, ebr_pkg::NO_ROW, 0);
        script_cfg(ebr_pkg::REG_WIDTH, 1);
        script_item(ebr_pkg::CMD_WRITE, ROWS - 1, 0, 16'sh7FFF, 0);
        script_item(ebr_pkg::CMD_WRITE, 0, 0, -16'sh8000, 0);
        script_item(ebr_pkg::CMD_ADD, ROWS - 1, 63, 0, 0);
        script_item(ebr_pkg::CMD_ADD_CLOSE, 0, 0, 0, 0, 1, -1, ebr_pkg::NO_ROW, 2);
        script_cfg(ebr_pkg::REG_MODE, ebr_pkg::RED_MAX);
        script_item(ebr_pkg::CMD_ADD, ROWS - 1, 0, 0, 0);
        script_item(ebr_pkg::CMD_ADD_CLOSE, 0, 0, 0, 0, 1, 32767, ROWS - 1, 2);
        script_item(ebr_pkg::CMD_ADD, 0, 0, 0, 0);
        script_item(ebr_pkg::CMD_ADD_CLOSE, 0, 0, 0, 0, 1, -32768, 0, 2);
        script_cfg(ebr_pkg::REG_PAD, 0);
        script_item(ebr_pkg::CMD_ADD_CLOSE, 0, 0, 0, 0, 1, 0, ebr_pkg::NO_ROW, 0);
        script_cfg(ebr_pkg::REG_MODE, ebr_pkg::RED_MEAN);
        script_cfg(ebr_pkg::REG_PAD, ebr_pkg::NO_ROW);
        script_cfg(ebr_pkg::REG_WEIGHT, 1);
        script_item(ebr_pkg::CMD_ADD, ROWS - 1, 0, 0, 16'sh7FFF);
        script_cfg(ebr_pkg::REG_MODE, ebr_pkg::RED_MAX);
        script_item(ebr_pkg::CMD_ADD, 0, 0, 0, -16'sh8000);
        script_cfg(ebr_pkg::REG_MODE, 2'd3);
        script_item(ebr_pkg::CMD_CLOSE, 0, 0, 0, 0);
        script_cfg(ebr_pkg::REG_WIDTH, 0);
        script_item(ebr_pkg::CMD_ADD_CLOSE, ROWS - 1, 0, 0, 16'sh0100);
        script_cfg(ebr_pkg::REG_WIDTH, 127);
        script_cfg(ebr_pkg::REG_WEIGHT, 0);
        script_item(ebr_pkg::CMD_CLOSE, 0, 0, 0, 0, 1, 0, ebr_pkg::NO_ROW, 0);

        foreach (script[i]) begin
            s = script[i];
            if (s.is_cfg)
                write_reg(ebr_pkg::reg_idx_t'(s.idx), s.data);
            else
                drive_item(ebr_pkg::cmd_t'(s.c), s.r, s.data[5:0], s.wd, s.wt, s.typed, s.tv,
                           s.tmr, s.tc);
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ebr_pkg::REG_MODE, ph_mode[ph]);
            write_reg(ebr_pkg::REG_WIDTH, ph_width[ph]);
            write_reg(ebr_pkg::REG_WEIGHT, ph_weighted[ph]);
            write_reg(ebr_pkg::REG_PAD, (ph % 3 == 0) ? ebr_pkg::NO_ROW
                                                      : 11'(pool[$urandom_range(POOL_N - 1)]));
            idle_pct = phase_idle[ph % 4];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) random_bag();
        end

        settle();
        if (pending_cols.size() != 0) begin
            $error("%0d expected column results never arrived", pending_cols.size());
            errors++;
        end
        $display("Ran %0d items and %0d bags, %0d column results checked,", items_sent,
                 bags_closed, results_seen);
        $display("over sum, mean, max and reserved modes, padding, weights and widths 1 to 64.");
        if (errors == 0)
            $display("** embedding_bag_reduce: PASSED **");
        else
            $display("** embedding_bag_reduce: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ebr_pkg.sv
hw/rtl/ebr_divider.sv
hw/rtl/ebr_table.sv
hw/rtl/ebr_accum.sv
hw/rtl/embedding_bag_reduce.sv
tb/sv/embedding_bag_reduce_test.sv
